[rtl/csz_pkg.sv]
// ----------------------------------------------------------------------------
// csz_pkg
// Shared types and constants for the CompactSize field parser.
// ----------------------------------------------------------------------------
package csz_pkg;

  // Payload widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned VALUE_W = 64;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register byte addresses
  localparam logic [CFG_ADDR_W-1:0] REG_WITH_PAYLOAD = 3'd0;

  // Header byte codes
  localparam logic [BYTE_W-1:0] HDR_U16 = 8'd253;
  localparam logic [BYTE_W-1:0] HDR_U32 = 8'd254;
  localparam logic [BYTE_W-1:0] HDR_BASE = 8'd252;

  // Canonical limits
  localparam logic [VALUE_W-1:0] MAX_U16 = 64'h0000_0000_0000_FFFF;
  localparam logic [VALUE_W-1:0] MAX_U32 = 64'h0000_0000_FFFF_FFFF;

  // Extension lengths in bytes
  localparam logic [3:0] EXT_LEN_U16 = 4'd2;
  localparam logic [3:0] EXT_LEN_U32 = 4'd4;
  localparam logic [3:0] EXT_LEN_U64 = 4'd8;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_EXT     = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    HK_NONE = 2'd0,
    HK_U16  = 2'd1,
    HK_U32  = 2'd2,
    HK_U64  = 2'd3
  } header_kind_t;

  typedef enum logic [1:0] {
    KIND_LENGTH  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic {
    ERR_NONCANON = 1'b0,
    ERR_TRUNC    = 1'b1
  } error_code_t;

  // Configuration state handed from the register block to the datapath
  typedef struct packed {
    logic with_payload;
  } csz_cfg_t;

endpackage

[rtl/csz_if.sv]
// ----------------------------------------------------------------------------
// csz_if
// Valid/ready channels for the input byte stream and the decoded results.
// ----------------------------------------------------------------------------
interface csz_byte_if;
  logic                         valid;
  logic                         ready;
  logic [csz_pkg::BYTE_W-1:0]   byte_in;
  logic                         buffer_end;

  modport source (output valid, output byte_in, output buffer_end, input ready);
  modport sink   (input valid, input byte_in, input buffer_end, output ready);
endinterface

interface csz_result_if;
  logic                         valid;
  logic                         ready;
  csz_pkg::kind_t               kind;
  logic [csz_pkg::VALUE_W-1:0]  value;
  csz_pkg::error_code_t         error_code;
  logic                         field_last;

  modport source (output valid, output kind, output value, output error_code,
                  output field_last, input ready);
  modport sink   (input valid, input kind, input value, input error_code,
                  input field_last, output ready);
endinterface

[rtl/csz_apb_regs.sv]
// ----------------------------------------------------------------------------
// csz_apb_regs
// APB-style configuration register block: holds the payload mode bit.
// ----------------------------------------------------------------------------
module csz_apb_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [csz_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [csz_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [csz_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  output csz_pkg::csz_cfg_t                 cfg
);
  import csz_pkg::*;

  logic with_payload;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == REG_WITH_PAYLOAD);

  // Write the mode bit in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      with_payload <= 1'b0;
    end else if (wr_en) begin
      with_payload <= pwdata[0];
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (paddr == REG_WITH_PAYLOAD) begin
      prdata[0] = with_payload;
    end
  end

  assign cfg.with_payload = with_payload;

endmodule

[rtl/compactsize_field_parser_top.sv]
// ----------------------------------------------------------------------------
// compactsize_field_parser_top
// Decodes CompactSize length fields from a byte stream, with optional
// payload pass-through.
//
// Usage:
//   stream  : one byte per item with a buffer_end mark on the last byte.
//   result  : zero or one item per input byte: a decoded length, a payload
//             byte, or an error (non-canonical or truncated buffer).
//   APB port: register 0 at byte address 0, bit 0 = payload mode.
// Timing:
//   An accepted byte is held in the input register, is decoded by the
//   parse logic and lands in the result register. One byte per cycle is
//   sustained while the receiver takes each result; the single-pass parse
//   step between the two registers sets that rate.
// Reset: rst (synchronous) clears both registers' valid flags, the parse
//   state and the mode bit; the parser then expects a header byte.
// Stall: a stalled receiver holds the result register; the input register
//   then holds its byte and stream.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module compactsize_field_parser_top (
  input  logic                              clk,
  input  logic                              rst,
  csz_byte_if.sink                          stream,
  csz_result_if.source                      result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [csz_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [csz_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [csz_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import csz_pkg::*;

  csz_cfg_t cfg;

  // Input register
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_end;

  // Parse state
  phase_t            phase, phase_next;
  header_kind_t      header_kind, header_kind_next;
  logic [3:0]        extension_left, extension_left_next;
  logic [2:0]        byte_position, byte_position_next;
  logic [VALUE_W-1:0] accumulator, accumulator_next;
  logic [VALUE_W-1:0] payload_left, payload_left_next;

  // Result register
  logic              out_valid;
  kind_t             out_kind;
  logic [VALUE_W-1:0] out_value;
  error_code_t       out_error_code;
  logic              out_last;

  // Parse step outputs
  logic              res_valid;
  kind_t             res_kind;
  logic [VALUE_W-1:0] res_value;
  error_code_t       res_error_code;
  logic              res_last;

  logic              advance;
  logic              do_finish;
  logic [VALUE_W-1:0] finish_len;
  logic [VALUE_W-1:0] acc_new;
  logic              bad;

  csz_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Advance the held item when the result register is free or draining
  assign advance      = in_valid && (!out_valid || result.ready);
  assign stream.ready = !in_valid || advance;

  // Capture the next item
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (stream.ready) begin
      in_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.ready && stream.valid) begin
      in_byte <= stream.byte_in;
      in_end  <= stream.buffer_end;
    end
  end

  // Parse one byte
  always_comb begin
    phase_next          = phase;
    header_kind_next    = header_kind;
    extension_left_next = extension_left;
    byte_position_next  = byte_position;
    accumulator_next    = accumulator;
    payload_left_next   = payload_left;
    res_valid           = 1'b0;
    res_kind            = KIND_LENGTH;
    res_value           = '0;
    res_error_code      = ERR_NONCANON;
    res_last            = 1'b0;
    do_finish           = 1'b0;
    finish_len          = '0;
    acc_new             = accumulator;
    bad                 = 1'b0;

    acc_new[{byte_position, 3'b000} +: BYTE_W] = in_byte;

    case (phase)
      PH_EXT: begin
        accumulator_next    = acc_new;
        byte_position_next  = byte_position + 3'd1;
        extension_left_next = extension_left - 4'd1;
        if (extension_left_next == 4'd0) begin
          bad = ((header_kind == HK_U16) && (acc_new < VALUE_W'(HDR_U16))) ||
                ((header_kind == HK_U32) && (acc_new <= MAX_U16)) ||
                ((header_kind == HK_U64) && (acc_new <= MAX_U32));
          if (bad) begin
            res_valid      = 1'b1;
            res_kind       = KIND_ERROR;
            res_error_code = ERR_NONCANON;
            res_last       = 1'b1;
            phase_next     = PH_HEADER;
          end else begin
            do_finish  = 1'b1;
            finish_len = acc_new;
          end
        end else if (in_end) begin
          res_valid      = 1'b1;
          res_kind       = KIND_ERROR;
          res_error_code = ERR_TRUNC;
          res_last       = 1'b1;
          phase_next     = PH_HEADER;
        end
      end
      PH_PAYLOAD: begin
        payload_left_next = payload_left - VALUE_W'(1);
        res_valid         = 1'b1;
        if (payload_left_next == '0) begin
          res_kind   = KIND_PAYLOAD;
          res_value  = VALUE_W'(in_byte);
          res_last   = 1'b1;
          phase_next = PH_HEADER;
        end else if (in_end) begin
          res_kind       = KIND_ERROR;
          res_error_code = ERR_TRUNC;
          res_last       = 1'b1;
          phase_next     = PH_HEADER;
        end else begin
          res_kind  = KIND_PAYLOAD;
          res_value = VALUE_W'(in_byte);
        end
      end
      default: begin
        // Header byte; an unused phase code is treated the same
        phase_next = PH_HEADER;
        if (in_byte < HDR_U16) begin
          do_finish  = 1'b1;
          finish_len = VALUE_W'(in_byte);
        end else if (in_end) begin
          res_valid      = 1'b1;
          res_kind       = KIND_ERROR;
          res_error_code = ERR_TRUNC;
          res_last       = 1'b1;
        end else begin
          header_kind_next    = header_kind_t'(2'(in_byte - HDR_BASE));
          extension_left_next = (in_byte == HDR_U16) ? EXT_LEN_U16 :
                                (in_byte == HDR_U32) ? EXT_LEN_U32 : EXT_LEN_U64;
          byte_position_next  = 3'd0;
          accumulator_next    = '0;
          phase_next          = PH_EXT;
        end
      end
    endcase

    // Complete a length field
    if (do_finish) begin
      res_valid = 1'b1;
      if (cfg.with_payload && (finish_len != '0)) begin
        if (in_end) begin
          res_kind       = KIND_ERROR;
          res_error_code = ERR_TRUNC;
          res_last       = 1'b1;
          phase_next     = PH_HEADER;
        end else begin
          res_kind          = KIND_LENGTH;
          res_value         = finish_len;
          res_last          = 1'b0;
          payload_left_next = finish_len;
          phase_next        = PH_PAYLOAD;
        end
      end else begin
        res_kind   = KIND_LENGTH;
        res_value  = finish_len;
        res_last   = 1'b1;
        phase_next = PH_HEADER;
      end
    end
  end

  // Update the parse state when an item advances
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      header_kind    <= HK_NONE;
      extension_left <= '0;
      byte_position  <= '0;
      accumulator    <= '0;
      payload_left   <= '0;
    end else if (advance) begin
      phase          <= phase_next;
      header_kind    <= header_kind_next;
      extension_left <= extension_left_next;
      byte_position  <= byte_position_next;
      accumulator    <= accumulator_next;
      payload_left   <= payload_left_next;
    end
  end

  // Result register: load on advance, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_kind       <= res_kind;
      out_value      <= res_value;
      out_error_code <= res_error_code;
      out_last       <= res_last;
    end
  end

  assign result.valid      = out_valid;
  assign result.kind       = out_kind;
  assign result.value      = out_value;
  assign result.error_code = out_error_code;
  assign result.field_last = out_last;

endmodule
